/* src/akca_pkg.sv */
// Shared types, constants and the microprogram of the angle Kalman filter.
// Used by every module of the block but akca_ram; depends on nothing else.
package akca_pkg;

  // Default binary points and the fixed widths of the words
  localparam int FRAC_BITS_DEF       = 32;
  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int EXT_FRAC            = 32;
  localparam int MEAS_W              = 25;
  localparam int STEP_W              = 32;
  localparam int QA_W                = 40;
  localparam int QV_W                = 40;
  localparam int QC_W                = 48;
  localparam int RN_W                = 40;
  localparam int CFG_W               = 48;
  localparam int S_TDATA_W           = 64;
  localparam int M_TDATA_W           = 160;
  localparam int REG_DEPTH           = 32;
  localparam int REG_AW              = 5;
  localparam int PC_W                = 6;

  typedef logic signed [63:0] q_t;
  typedef logic [5:0]         src_t;

  localparam q_t Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q_t Q_MIN = 64'sh8000_0000_0000_0000;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_QA = 2'd0,
    CFG_QV = 2'd1,
    CFG_QC = 2'd2,
    CFG_RN = 2'd3
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_READ,
    ST_EXEC,
    ST_WAIT,
    ST_OUT
  } st_t;

  // Micro-operations
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_ASR1,
    OP_WRAP,
    OP_MUL,
    OP_DIV,
    OP_MOD,
    OP_END
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [REG_AW-1:0] dst;
    src_t              a;
    src_t              b;
  } micro_t;

  // Divider control word
  typedef struct packed {
    logic start;
    logic mod_mode;
  } div_ctl_t;

  // Register file slots: state first, then scratch
  localparam src_t R_X0 = 6'd0;
  localparam src_t R_X1 = 6'd1;
  localparam src_t R_X2 = 6'd2;
  localparam src_t R_P0 = 6'd3;
  localparam src_t R_P1 = 6'd4;
  localparam src_t R_P2 = 6'd5;
  localparam src_t R_P3 = 6'd6;
  localparam src_t R_P4 = 6'd7;
  localparam src_t R_P5 = 6'd8;
  localparam src_t R_T  = 6'd9;
  localparam src_t R_U  = 6'd10;
  localparam src_t R_H  = 6'd11;
  localparam src_t R_XT = 6'd12;
  localparam src_t R_XV = 6'd13;
  localparam src_t R_A0 = 6'd14;
  localparam src_t R_A1 = 6'd15;
  localparam src_t R_A2 = 6'd16;
  localparam src_t R_A4 = 6'd17;
  localparam src_t R_A5 = 6'd18;
  localparam src_t R_PP00 = 6'd19;
  localparam src_t R_PP01 = 6'd20;
  localparam src_t R_PP11 = 6'd21;
  localparam src_t R_PP22 = 6'd22;
  localparam src_t R_Y  = 6'd23;
  localparam src_t R_R  = 6'd24;
  localparam src_t R_S  = 6'd25;
  localparam src_t R_K0 = 6'd26;
  localparam src_t R_K1 = 6'd27;
  localparam src_t R_K2 = 6'd28;
  localparam src_t R_OMK = 6'd29;

  // Operand sources outside the register file
  localparam src_t SRC_DT   = 6'd32;
  localparam src_t SRC_MEAS = 6'd33;
  localparam src_t SRC_QA   = 6'd34;
  localparam src_t SRC_QV   = 6'd35;
  localparam src_t SRC_QC   = 6'd36;
  localparam src_t SRC_RN   = 6'd37;
  localparam src_t SRC_ONE  = 6'd38;
  localparam src_t SRC_D360 = 6'd39;
  localparam src_t SRC_NONE = 6'd40;

  function automatic micro_t mi(input op_t op, input src_t d, input src_t a, input src_t b);
    micro_t m;
    m.op  = op;
    m.dst = d[REG_AW-1:0];
    m.a   = a;
    m.b   = b;
    return m;
  endfunction

  // One filter update as a list of register-file operations
  function automatic micro_t micro_rom(input logic [PC_W-1:0] pc);
    micro_t m;
    unique case (pc)
      // prediction of the state
      6'd0:  m = mi(OP_MUL,  R_T,    SRC_DT,  SRC_DT);
      6'd1:  m = mi(OP_ASR1, R_H,    R_T,     SRC_NONE);
      6'd2:  m = mi(OP_MUL,  R_T,    R_X1,    SRC_DT);
      6'd3:  m = mi(OP_ADD,  R_T,    R_X0,    R_T);
      6'd4:  m = mi(OP_MUL,  R_U,    R_X2,    R_H);
      6'd5:  m = mi(OP_ADD,  R_XT,   R_T,     R_U);
      6'd6:  m = mi(OP_MUL,  R_T,    R_X2,    SRC_DT);
      6'd7:  m = mi(OP_ADD,  R_XV,   R_X1,    R_T);
      // F * P
      6'd8:  m = mi(OP_MUL,  R_T,    SRC_DT,  R_P1);
      6'd9:  m = mi(OP_ADD,  R_T,    R_P0,    R_T);
      6'd10: m = mi(OP_MUL,  R_U,    R_H,     R_P2);
      6'd11: m = mi(OP_ADD,  R_A0,   R_T,     R_U);
      6'd12: m = mi(OP_MUL,  R_T,    SRC_DT,  R_P3);
      6'd13: m = mi(OP_ADD,  R_T,    R_P1,    R_T);
      6'd14: m = mi(OP_MUL,  R_U,    R_H,     R_P4);
      6'd15: m = mi(OP_ADD,  R_A1,   R_T,     R_U);
      6'd16: m = mi(OP_MUL,  R_T,    SRC_DT,  R_P4);
      6'd17: m = mi(OP_ADD,  R_T,    R_P2,    R_T);
      6'd18: m = mi(OP_MUL,  R_U,    R_H,     R_P5);
      6'd19: m = mi(OP_ADD,  R_A2,   R_T,     R_U);
      6'd20: m = mi(OP_MUL,  R_T,    SRC_DT,  R_P4);
      6'd21: m = mi(OP_ADD,  R_A4,   R_P3,    R_T);
      6'd22: m = mi(OP_MUL,  R_T,    SRC_DT,  R_P5);
      6'd23: m = mi(OP_ADD,  R_A5,   R_P4,    R_T);
      // predicted covariance
      6'd24: m = mi(OP_MUL,  R_T,    SRC_DT,  R_A1);
      6'd25: m = mi(OP_ADD,  R_T,    R_A0,    R_T);
      6'd26: m = mi(OP_MUL,  R_U,    R_H,     R_A2);
      6'd27: m = mi(OP_ADD,  R_T,    R_T,     R_U);
      6'd28: m = mi(OP_ADD,  R_PP00, R_T,     SRC_QA);
      6'd29: m = mi(OP_MUL,  R_T,    SRC_DT,  R_A2);
      6'd30: m = mi(OP_ADD,  R_PP01, R_A1,    R_T);
      6'd31: m = mi(OP_MUL,  R_T,    SRC_DT,  R_A5);
      6'd32: m = mi(OP_ADD,  R_T,    R_A4,    R_T);
      6'd33: m = mi(OP_ADD,  R_PP11, R_T,     SRC_QV);
      6'd34: m = mi(OP_ADD,  R_PP22, R_P5,    SRC_QC);
      // innovation, wrapped
      6'd35: m = mi(OP_SUB,  R_Y,    SRC_MEAS, R_XT);
      6'd36: m = mi(OP_MOD,  R_R,    R_Y,     SRC_D360);
      6'd37: m = mi(OP_WRAP, R_Y,    R_Y,     R_R);
      // gains
      6'd38: m = mi(OP_ADD,  R_S,    R_PP00,  SRC_RN);
      6'd39: m = mi(OP_DIV,  R_K0,   R_PP00,  R_S);
      6'd40: m = mi(OP_DIV,  R_K1,   R_PP01,  R_S);
      6'd41: m = mi(OP_DIV,  R_K2,   R_A2,    R_S);
      // state correction
      6'd42: m = mi(OP_MUL,  R_T,    R_K0,    R_Y);
      6'd43: m = mi(OP_ADD,  R_T,    R_XT,    R_T);
      6'd44: m = mi(OP_MOD,  R_X0,   R_T,     SRC_D360);
      6'd45: m = mi(OP_MUL,  R_T,    R_K1,    R_Y);
      6'd46: m = mi(OP_ADD,  R_X1,   R_XV,    R_T);
      6'd47: m = mi(OP_MUL,  R_T,    R_K2,    R_Y);
      6'd48: m = mi(OP_ADD,  R_X2,   R_X2,    R_T);
      // covariance update
      6'd49: m = mi(OP_SUB,  R_OMK,  SRC_ONE, R_K0);
      6'd50: m = mi(OP_MUL,  R_P0,   R_OMK,   R_PP00);
      6'd51: m = mi(OP_MUL,  R_P1,   R_OMK,   R_PP01);
      6'd52: m = mi(OP_MUL,  R_P2,   R_OMK,   R_A2);
      6'd53: m = mi(OP_MUL,  R_T,    R_K1,    R_PP01);
      6'd54: m = mi(OP_SUB,  R_P3,   R_PP11,  R_T);
      6'd55: m = mi(OP_MUL,  R_T,    R_K1,    R_A2);
      6'd56: m = mi(OP_SUB,  R_P4,   R_A5,    R_T);
      6'd57: m = mi(OP_MUL,  R_T,    R_K2,    R_A2);
      6'd58: m = mi(OP_SUB,  R_P5,   R_PP22,  R_T);
      default: m = mi(OP_END, R_T,   SRC_NONE, SRC_NONE);
    endcase
    return m;
  endfunction

  // Clamp a 65-bit sum into the signed 64-bit range
  function automatic q_t sat65(input logic signed [64:0] s);
    if (s[64] != s[63]) begin
      return s[64] ? Q_MIN : Q_MAX;
    end
    return s[63:0];
  endfunction

  // Magnitude as an unsigned word; the most negative value maps to 2^63
  function automatic logic [63:0] mag(input q_t v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  // Move the binary point: floor when shifting right, saturate when left
  function automatic q_t rescale(input q_t v, input int from_b, input int to_b);
    q_t lim;
    int s;
    s = to_b - from_b;
    if (s < 0) begin
      return v >>> (from_b - to_b);
    end
    if (s == 0) begin
      return v;
    end
    lim = Q_MAX >>> s;
    if (v > lim) begin
      return Q_MAX;
    end
    if (v < -lim - 64'sd1) begin
      return Q_MIN;
    end
    return v <<< s;
  endfunction

endpackage

/* src/akca_ram.sv */
// Generic register-file RAM: one write port, two registered read ports.
// Standalone; no package needed.
module akca_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register both reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* src/akca_mul.sv */
// Bit-serial fixed-point multiplier: one multiplier bit per cycle.
// Depends on akca_pkg for the word type and saturation limits.
module akca_mul import akca_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  q_t   a,
  input  q_t   b,
  output logic done,
  output q_t   result
);

  logic [63:0]  ua;
  logic [127:0] prod;
  logic         neg;
  logic [5:0]   cnt;
  logic         busy;
  logic         fin;

  logic [64:0]         upper;
  logic [127:0]        pn;
  logic signed [127:0] sh;

  // One shift-add step and the final sign, scale and clamp
  always_comb begin
    upper = {1'b0, prod[127:64]} + (prod[0] ? {1'b0, ua} : 65'd0);
    pn    = neg ? (~prod + 128'd1) : prod;
    sh    = $signed(pn) >>> FRAC_BITS;
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      ua   <= mag(a);
      prod <= {64'd0, mag(b)};
      neg  <= a[63] ^ b[63];
    end else if (busy) begin
      prod <= {upper, prod[63:1]};
    end else if (fin) begin
      if ((&sh[127:63]) || !(|sh[127:63])) begin
        result <= sh[63:0];
      end else begin
        result <= sh[127] ? Q_MIN : Q_MAX;
      end
    end
  end

endmodule

/* src/akca_div.sv */
// Bit-serial restoring divider: fixed-point quotient or a modulo remainder.
// Depends on akca_pkg for the word type, limits and control struct.
module akca_div import akca_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  div_ctl_t ctl,
  input  q_t       n,
  input  q_t       d,
  output logic     done,
  output q_t       result
);

  logic [127:0] nq;
  logic [63:0]  rem;
  logic [63:0]  ud;
  logic         neg;
  logic         neg_n;
  logic         dzero;
  logic         mode;
  logic [6:0]   cnt;
  logic         busy;
  logic         fin;

  logic [64:0] r2;
  logic        ge;
  logic [63:0] qhi;
  logic [63:0] qlo;

  // One quotient bit per cycle
  always_comb begin
    r2  = {rem, nq[127]};
    ge  = r2 >= {1'b0, ud};
    qhi = nq[127:64];
    qlo = nq[63:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd127) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      nq    <= ctl.mod_mode ? {64'd0, mag(n)} : ({64'd0, mag(n)} << FRAC_BITS);
      rem   <= '0;
      ud    <= mag(d);
      neg   <= n[63] ^ d[63];
      neg_n <= n[63];
      dzero <= (d == '0);
      mode  <= ctl.mod_mode;
    end else if (busy) begin
      rem <= ge ? 64'(r2 - {1'b0, ud}) : r2[63:0];
      nq  <= {nq[126:0], ge};
    end else if (fin) begin
      if (mode) begin
        result <= (neg_n && rem != '0) ? q_t'(ud - rem) : q_t'(rem);
      end else if (dzero) begin
        result <= '0;
      end else if (neg) begin
        if (qhi != '0 || qlo > 64'h8000_0000_0000_0000) begin
          result <= Q_MIN;
        end else begin
          result <= q_t'(~qlo + 64'd1);
        end
      end else begin
        if (qhi != '0 || qlo[63]) begin
          result <= Q_MAX;
        end else begin
          result <= q_t'(qlo);
        end
      end
    end
  end

endmodule

/* src/angle_kalman_const_accel.sv */
// Three-state angle Kalman filter: microcoded sequencer, register file and ALU.
// Depends on akca_pkg, akca_ram, akca_mul and akca_div.
//
//  Channel  Dir  Handshake          Word
//  s_*      in   s_tvalid/s_tready  meas_angle[24:0], step_seconds[56:25]
//  m_*      out  m_tvalid/m_tready  est_angle[24:0], est_velocity, est_accel
//  cfg_*    in   cfg_we             register cfg_addr, value cfg_data
//
// Each word runs 60 micro-operations, of which 25 run on the bit-serial
// multiplier and 5 on the bit-serial divider (quotient or modulo 360).
// Reset clears control state and marks the register file unwritten; the
// state slots then read as zero state and unit diagonal covariance.
// A new word is taken while a result waits in the output register; the
// sequencer stalls only at the end of a word until that register is free.
module angle_kalman_const_accel import akca_pkg::*; #(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // meas_angle, step_seconds
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // est_angle, est_velocity, est_accel
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_addr,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam q_t ONE_Q  = q_t'(64'sd1 <<< FRAC_BITS);
  localparam q_t DEG180 = q_t'(64'sd180 <<< FRAC_BITS);
  localparam q_t DEG360 = q_t'(64'sd360 <<< FRAC_BITS);

  st_t             state, state_next;
  logic [PC_W-1:0] pc;
  micro_t          inst;
  src_t            a_q, b_q;
  q_t              opa, opb, opa_next, opb_next;
  q_t              meas_q, dt_q;
  logic [QA_W-1:0] qa;
  logic [QV_W-1:0] qv;
  logic [QC_W-1:0] qc;
  logic [RN_W-1:0] rn;
  logic [REG_DEPTH-1:0] valid;
  q_t              xo0, xo1, xo2;
  q_t              ang_out;

  logic            ram_we;
  q_t              ram_wdata;
  logic [63:0]     rdata_a, rdata_b;
  logic            pc_inc;
  logic            load_out;
  logic            mul_start, mul_done;
  q_t              mul_res, div_res;
  div_ctl_t        div_ctl;
  logic            div_done;
  q_t              alu;

  assign inst     = micro_rom(pc);
  assign s_tready = (state == ST_IDLE);
  assign ang_out  = rescale(xo0, FRAC_BITS, ANGLE_FRAC_BITS);

  akca_ram #(.WIDTH(64), .DEPTH(REG_DEPTH)) u_regs (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (inst.dst),
    .wdata   (ram_wdata),
    .raddr_a (inst.a[REG_AW-1:0]),
    .raddr_b (inst.b[REG_AW-1:0]),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  akca_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (opa),
    .b      (opb),
    .done   (mul_done),
    .result (mul_res)
  );

  akca_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst    (rst),
    .ctl    (div_ctl),
    .n      (opa),
    .d      (opb),
    .done   (div_done),
    .result (div_res)
  );

  // Unwritten state slots read as their reset value
  function automatic q_t slot_reset(input logic [REG_AW-1:0] addr);
    if (addr == R_P0[REG_AW-1:0] || addr == R_P3[REG_AW-1:0] || addr == R_P5[REG_AW-1:0]) begin
      return ONE_Q;
    end
    return '0;
  endfunction

  function automatic q_t pick(input src_t s, input logic [63:0] rd,
                              input logic [REG_DEPTH-1:0] vld, input q_t meas,
                              input q_t dt, input q_t cqa, input q_t cqv,
                              input q_t cqc, input q_t crn);
    if (!s[5]) begin
      return vld[s[REG_AW-1:0]] ? q_t'(rd) : slot_reset(s[REG_AW-1:0]);
    end
    unique case (s)
      SRC_DT:   return dt;
      SRC_MEAS: return meas;
      SRC_QA:   return cqa;
      SRC_QV:   return cqv;
      SRC_QC:   return cqc;
      SRC_RN:   return crn;
      SRC_ONE:  return ONE_Q;
      SRC_D360: return DEG360;
      default:  return '0;
    endcase
  endfunction

  // Select operands from the register file or the fixed sources
  always_comb begin
    opa_next = pick(a_q, rdata_a, valid, meas_q, dt_q,
                    rescale(q_t'({24'd0, qa}), EXT_FRAC, FRAC_BITS),
                    rescale(q_t'({24'd0, qv}), EXT_FRAC, FRAC_BITS),
                    rescale(q_t'({16'd0, qc}), EXT_FRAC, FRAC_BITS),
                    rescale(q_t'({24'd0, rn}), EXT_FRAC, FRAC_BITS));
    opb_next = pick(b_q, rdata_b, valid, meas_q, dt_q,
                    rescale(q_t'({24'd0, qa}), EXT_FRAC, FRAC_BITS),
                    rescale(q_t'({24'd0, qv}), EXT_FRAC, FRAC_BITS),
                    rescale(q_t'({16'd0, qc}), EXT_FRAC, FRAC_BITS),
                    rescale(q_t'({24'd0, rn}), EXT_FRAC, FRAC_BITS));
  end

  // Combinational ALU: saturating add and subtract, halve, innovation wrap
  always_comb begin
    unique case (inst.op)
      OP_ADD:  alu = sat65({opa[63], opa} + {opb[63], opb});
      OP_SUB:  alu = sat65({opa[63], opa} - {opb[63], opb});
      OP_ASR1: alu = opa >>> 1;
      OP_WRAP: begin
        if (opa > DEG180) begin
          alu = (opb > DEG180) ? (opb - DEG360) : opb;
        end else if (opa < -DEG180) begin
          alu = (opb >= DEG180) ? (opb - DEG360) : opb;
        end else begin
          alu = opa;
        end
      end
      default: alu = opa;
    endcase
  end

  // Next state and control strobes
  always_comb begin
    state_next       = state;
    ram_we           = 1'b0;
    ram_wdata        = alu;
    pc_inc           = 1'b0;
    load_out         = 1'b0;
    mul_start        = 1'b0;
    div_ctl.start    = 1'b0;
    div_ctl.mod_mode = (inst.op == OP_MOD);
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_READ;
      ST_READ:  state_next = ST_EXEC;
      ST_EXEC: begin
        unique case (inst.op)
          OP_MUL: begin
            mul_start  = 1'b1;
            state_next = ST_WAIT;
          end
          OP_DIV, OP_MOD: begin
            div_ctl.start = 1'b1;
            state_next    = ST_WAIT;
          end
          OP_END: state_next = ST_OUT;
          default: begin
            ram_we     = 1'b1;
            pc_inc     = 1'b1;
            state_next = ST_FETCH;
          end
        endcase
      end
      ST_WAIT: begin
        if (inst.op == OP_MUL && mul_done) begin
          ram_we     = 1'b1;
          ram_wdata  = mul_res;
          pc_inc     = 1'b1;
          state_next = ST_FETCH;
        end else if (inst.op != OP_MUL && div_done) begin
          ram_we     = 1'b1;
          ram_wdata  = div_res;
          pc_inc     = 1'b1;
          state_next = ST_FETCH;
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State, program counter and valid marks
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= '0;
      valid <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && s_tvalid) begin
        pc <= '0;
      end else if (pc_inc) begin
        pc <= pc + 6'd1;
      end
      if (ram_we) begin
        valid[inst.dst] <= 1'b1;
      end
    end
  end

  // Configuration registers, masked to their widths
  always_ff @(posedge clk) begin
    if (rst) begin
      qa <= QA_W'(429497);
      qv <= QV_W'(42949673);
      qc <= QC_W'(64'd4294967296);
      rn <= RN_W'(42949673);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_QA: qa <= cfg_data[QA_W-1:0];
        CFG_QV: qv <= cfg_data[QV_W-1:0];
        CFG_QC: qc <= cfg_data[QC_W-1:0];
        CFG_RN: rn <= cfg_data[RN_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input word, operands and corrected state copies
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      meas_q <= rescale(q_t'({39'd0, s_tdata[MEAS_W-1:0]}), ANGLE_FRAC_BITS, FRAC_BITS);
      dt_q   <= rescale(q_t'({32'd0, s_tdata[MEAS_W +: STEP_W]}), EXT_FRAC, FRAC_BITS);
    end
    if (state == ST_FETCH) begin
      a_q <= inst.a;
      b_q <= inst.b;
    end
    if (state == ST_READ) begin
      opa <= opa_next;
      opb <= opb_next;
    end
    if (ram_we && inst.dst == R_X0[REG_AW-1:0]) begin
      xo0 <= ram_wdata;
    end
    if (ram_we && inst.dst == R_X1[REG_AW-1:0]) begin
      xo1 <= ram_wdata;
    end
    if (ram_we && inst.dst == R_X2[REG_AW-1:0]) begin
      xo2 <= ram_wdata;
    end
  end

  // Output register: hold the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {7'd0,
                  rescale(xo2, FRAC_BITS, EXT_FRAC),
                  rescale(xo1, FRAC_BITS, EXT_FRAC),
                  ang_out[MEAS_W-1:0]};
    end
  end

  // Checks
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ram_we) else $error("register file written while idle");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    (mul_done || div_done) |-> (state == ST_WAIT)) else $error("unit finished outside wait");

  a_accept_restart: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_FETCH && pc == '0))
    else $error("accepted word did not restart the program");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load_out |=> m_tvalid) else $error("loaded result not shown");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the three-state angle Kalman filter.
// Depends on akca_pkg and the angle_kalman_const_accel RTL; a built-in filter model predicts
// every result word, and each word the block emits is checked against it.
module testbench;
  import akca_pkg::*;

  typedef struct packed {
    logic [24:0] angle;
    logic [31:0] step;
  } meas_t;

  // Lowest field last, matching the result word layout
  typedef struct packed {
    q_t          acc;
    q_t          vel;
    logic [24:0] angle;
  } est_t;

  localparam q_t ONE    = 64'sh1_0000_0000;
  localparam q_t DEG180 = 64'sd180 <<< 32;
  localparam q_t DEG360 = 64'sd360 <<< 32;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_we;
  logic [1:0]           cfg_addr;
  logic [CFG_W-1:0]     cfg_data;

  // Filter model state and register copies
  q_t          kin [3];
  q_t          cov [6];
  logic [63:0] noise [4];

  meas_t pending_meas [$];
  est_t  est_queue [$];
  int    n_sent;
  int    n_recv;
  int    n_fail;
  int    hold_left;
  bit    hold_done;

  angle_kalman_const_accel uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Saturating fixed-point helpers
  function automatic q_t sat128(input logic signed [127:0] v);
    if (v[127:63] != {65{v[127]}}) begin
      return v[127] ? Q_MIN : Q_MAX;
    end
    return v[63:0];
  endfunction

  function automatic q_t fx_add(input q_t a, input q_t b);
    logic signed [127:0] aw, bw;
    aw = a;
    bw = b;
    return sat128(aw + bw);
  endfunction

  function automatic q_t fx_sub(input q_t a, input q_t b);
    logic signed [127:0] aw, bw;
    aw = a;
    bw = b;
    return sat128(aw - bw);
  endfunction

  function automatic q_t fx_mul(input q_t a, input q_t b);
    logic signed [127:0] aw, bw;
    aw = a;
    bw = b;
    return sat128((aw * bw) >>> 32);
  endfunction

  function automatic q_t fx_mac(input q_t acc, input q_t a, input q_t b);
    return fx_add(acc, fx_mul(a, b));
  endfunction

  function automatic q_t fx_div(input q_t n, input q_t d);
    logic signed [127:0] nw, dw;
    if (d == 0) begin
      return 0;
    end
    nw = n;
    dw = d;
    return sat128((nw <<< 32) / dw);
  endfunction

  function automatic q_t wrap360(input q_t v);
    q_t r;
    r = v % DEG360;
    if (r < 0) begin
      r = r + DEG360;
    end
    return r;
  endfunction

  // One predict/correct step of the filter; advances the model state
  function automatic est_t filter_step(input meas_t m);
    q_t meas, dt, h, xt, xv, xa, a0, a1, a2, a4, a5;
    q_t pp00, pp01, pp02, pp11, pp12, pp22, y, r, s, k0, k1, k2, omk, ang;
    est_t e;
    meas = {39'b0, m.angle} <<< 16;
    dt   = {32'b0, m.step};
    h  = fx_mul(dt, dt) >>> 1;
    xt = fx_mac(fx_mac(kin[0], kin[1], dt), kin[2], h);
    xv = fx_mac(kin[1], kin[2], dt);
    xa = kin[2];
    a0 = fx_mac(fx_mac(cov[0], dt, cov[1]), h, cov[2]);
    a1 = fx_mac(fx_mac(cov[1], dt, cov[3]), h, cov[4]);
    a2 = fx_mac(fx_mac(cov[2], dt, cov[4]), h, cov[5]);
    a4 = fx_mac(cov[3], dt, cov[4]);
    a5 = fx_mac(cov[4], dt, cov[5]);
    pp00 = fx_add(fx_mac(fx_mac(a0, dt, a1), h, a2), q_t'(noise[CFG_QA]));
    pp01 = fx_mac(a1, dt, a2);
    pp02 = a2;
    pp11 = fx_add(fx_mac(a4, dt, a5), q_t'(noise[CFG_QV]));
    pp12 = a5;
    pp22 = fx_add(cov[5], q_t'(noise[CFG_QC]));
    // wrap the innovation into half a turn either way
    y = fx_sub(meas, xt);
    if (y > DEG180) begin
      r = wrap360(y);
      y = (r > DEG180) ? r - DEG360 : r;
    end else if (y < -DEG180) begin
      r = wrap360(y);
      y = (r >= DEG180) ? r - DEG360 : r;
    end
    s  = fx_add(pp00, q_t'(noise[CFG_RN]));
    k0 = fx_div(pp00, s);
    k1 = fx_div(pp01, s);
    k2 = fx_div(pp02, s);
    kin[0] = wrap360(fx_mac(xt, k0, y));
    kin[1] = fx_mac(xv, k1, y);
    kin[2] = fx_mac(xa, k2, y);
    omk = fx_sub(ONE, k0);
    cov[0] = fx_mul(omk, pp00);
    cov[1] = fx_mul(omk, pp01);
    cov[2] = fx_mul(omk, pp02);
    cov[3] = fx_sub(pp11, fx_mul(k1, pp01));
    cov[4] = fx_sub(pp12, fx_mul(k1, pp02));
    cov[5] = fx_sub(pp22, fx_mul(k2, pp02));
    ang = kin[0] >>> 16;
    e.angle = ang[24:0];
    e.vel   = kin[1];
    e.acc   = kin[2];
    return e;
  endfunction

  // Driver: offer words from the pending queue, predict on acceptance
  always @(posedge clk) begin
    meas_t pm;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      n_sent   = 0;
      kin      = '{0, 0, 0};
      cov      = '{ONE, 0, 0, ONE, 0, ONE};
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        est_queue.push_back(filter_step(meas_t'({s_tdata[24:0], s_tdata[56:25]})));
        n_sent++;
      end
      if (pending_meas.size() > 0 &&
          ((n_sent > 250 && n_sent < 400) || $urandom_range(99) >= 17)) begin
        pm = pending_meas.pop_front();
        s_tdata  <= {7'b0, pm.step, pm.angle};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each result word; hold off once for a long stretch
  always @(posedge clk) begin
    est_t got, want;
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
      n_recv    = 0;
      n_fail    = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[152:0];
        n_recv++;
        if (est_queue.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          n_fail++;
        end else begin
          want = est_queue.pop_front();
          if (got.angle !== want.angle) begin
            $display("%0t: est_angle expected %h actual %h", $time, want.angle, got.angle);
            n_fail++;
          end
          if (got.vel !== want.vel) begin
            $display("%0t: est_velocity expected %h actual %h", $time, want.vel, got.vel);
            n_fail++;
          end
          if (got.acc !== want.acc) begin
            $display("%0t: est_accel expected %h actual %h", $time, want.acc, got.acc);
            n_fail++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else if (!hold_done && n_recv == 30) begin
        hold_done <= 1'b1;
        hold_left <= 12000;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= (n_recv > 300 && n_recv < 450) || $urandom_range(99) >= 17;
      end
    end
  end

  // Let the block drain, including the tail of a word in flight
  task automatic wait_drained();
    while (pending_meas.size() > 0 || s_tvalid || est_queue.size() > 0) begin
      @(posedge clk);
    end
    repeat (3000) @(posedge clk);
  endtask

  task automatic write_noise(input logic [47:0] qa, input logic [47:0] qv,
                             input logic [47:0] qc, input logic [47:0] rn);
    logic [47:0] vals [4];
    cfg_idx_t idx;
    vals = '{qa, qv, qc, rn};
    for (int i = 0; i < 4; i++) begin
      idx = cfg_idx_t'(i);
      @(posedge clk);
      cfg_we   <= 1'b1;
      cfg_addr <= idx;
      cfg_data <= vals[i];
      noise[i] = (idx == CFG_QC) ? vals[i] : {24'b0, vals[i][39:0]};
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic meas_t rand_meas(input bit wide_dt);
    meas_t m;
    m.angle = $urandom_range(9) == 0 ? 25'($urandom) : 25'($urandom_range(23592959));
    m.step  = wide_dt ? $urandom : $urandom_range(32'h0400_0000);
    return m;
  endfunction

  // Limit on the whole run
  initial begin
    #40000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [47:0] r [4];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = CFG_QA;
    cfg_data = '0;
    noise = '{64'd429497, 64'd42949673, 64'd4294967296, 64'd42949673};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes under the reset noise values
    pending_meas.push_back('{25'd0, 32'd0});
    pending_meas.push_back('{25'h1FF_FFFF, 32'hFFFF_FFFF});
    pending_meas.push_back('{25'd23592959, 32'd1});
    pending_meas.push_back('{25'd11796480, 32'h8000_0000});
    pending_meas.push_back('{25'd0, 32'hFFFF_FFFF});
    pending_meas.push_back('{25'd23592960, 32'h0100_0000});
    pending_meas.push_back('{25'h155_5555, 32'hAAAA_AAAA});
    pending_meas.push_back('{25'h0AA_AAAA, 32'h5555_5555});
    for (int i = 0; i < 40; i++) pending_meas.push_back(rand_meas(i % 3 == 0));
    wait_drained();

    // All noise zero: gain of one, then zero steps give a zero innovation covariance
    write_noise(48'd0, 48'd0, 48'd0, 48'd0);
    for (int i = 0; i < 6; i++) pending_meas.push_back('{25'($urandom_range(23592959)), 32'd0});
    pending_meas.push_back('{25'd1000, 32'h0010_0000});
    for (int i = 0; i < 4; i++) pending_meas.push_back('{25'($urandom), 32'd0});
    wait_drained();

    // Every register at its top; the 40-bit ones also get bits above their width set
    write_noise('1, '1, '1, '1);
    for (int i = 0; i < 60; i++) pending_meas.push_back(rand_meas(i % 2 == 0));
    wait_drained();

    // Random settings, mostly short time steps
    for (int ph = 0; ph < 6; ph++) begin
      foreach (r[k]) r[k] = 48'({$urandom, $urandom} >> $urandom_range(47));
      write_noise(r[0], r[1], r[2], r[3]);
      for (int i = 0; i < 130; i++) pending_meas.push_back(rand_meas($urandom_range(7) == 0));
      wait_drained();
    end

    $display("Ran %0d measurements through nine noise settings, zero and full-scale", n_sent);
    $display("included, with %0d estimates checked and one long output stall.", n_recv);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
